// ===== rtl/core/numeric_char_reference_decoder_macros.svh =====
// Assertion macros shared by the decoder RTL.
`ifndef NUMERIC_CHAR_REFERENCE_DECODER_MACROS_SVH
`define NUMERIC_CHAR_REFERENCE_DECODER_MACROS_SVH

`ifndef ASSERT_OFF

// Checked on every rising clock edge outside reset.
`define NCR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define NCR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define NCR_ASSERT(lbl, prop, msg)
`define NCR_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== rtl/core/ncr_pkg.sv =====
package ncr_pkg;

    // One result item as it leaves the block.
    typedef struct packed {
        logic        has_char;
        logic [20:0] code_point;
        logic        from_reference;
        logic        out_of_range;
        logic        last_out;
    } ncr_item_t;

    // Results produced by one accepted byte: count, then up to two items in order.
    typedef struct packed {
        logic [1:0] count;
        ncr_item_t  first;
        ncr_item_t  second;
    } ncr_push_t;

    localparam logic [1:0] PUSH_NONE = 2'd0;
    localparam logic [1:0] PUSH_ONE  = 2'd1;
    localparam logic [1:0] PUSH_TWO  = 2'd2;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [20:0] CP_MAX  = 21'h10FFFF;
    localparam logic [21:0] ACC_SAT = 22'h110000;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

endpackage

// ===== rtl/core/ncr_in_if.sv =====
interface ncr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       end_of_text;

    modport source (output valid, output byte_in, output end_of_text, input ready);
    modport sink   (input valid, input byte_in, input end_of_text, output ready);
endinterface

// ===== rtl/core/ncr_out_if.sv =====
interface ncr_out_if;
    logic        valid;
    logic        ready;
    logic        has_char;
    logic [20:0] code_point;
    logic        from_reference;
    logic        out_of_range;
    logic        last_out;

    modport source (
        output valid, output has_char, output code_point, output from_reference,
        output out_of_range, output last_out, input ready
    );
    modport sink (
        input valid, input has_char, input code_point, input from_reference,
        input out_of_range, input last_out, output ready
    );
endinterface

// ===== rtl/core/ncr_queue.sv =====
`include "numeric_char_reference_decoder_macros.svh"

module ncr_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  ncr_pkg::ncr_push_t push,
    output logic              room,
    ncr_out_if.source         chars
);
    import ncr_pkg::*;

    ncr_item_t           slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   wr_ptr_inc;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                pop;
    ncr_item_t           head;

    assign wr_ptr_inc = wr_ptr_reg + QPTR_W'(1);
    assign pop        = chars.valid && chars.ready;
    assign room       = count_reg <= QCNT_W'(QDEPTH - 2);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push.count) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Each slot takes the first item at the write pointer, the second one past it.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            if (push.count != PUSH_NONE && QPTR_W'(i) == wr_ptr_reg)
            begin
                slot_reg[i] <= push.first;
            end
            else if (push.count == PUSH_TWO && QPTR_W'(i) == wr_ptr_inc)
            begin
                slot_reg[i] <= push.second;
            end
        end
    end

    assign head                 = slot_reg[rd_ptr_reg];
    assign chars.valid          = count_reg != '0;
    assign chars.has_char       = head.has_char;
    assign chars.code_point     = head.code_point;
    assign chars.from_reference = head.from_reference;
    assign chars.out_of_range   = head.out_of_range;
    assign chars.last_out       = head.last_out;

    `NCR_ASSERT_ALWAYS(a_count_bound, count_reg <= QCNT_W'(QDEPTH), "result queue overfilled")
    `NCR_ASSERT(a_two_needs_room, push.count == PUSH_TWO |-> room, "double push without room")
    `NCR_ASSERT(a_push_code, push.count <= PUSH_TWO, "more than two results from one byte")
    `NCR_ASSERT(a_ptr_gap, count_reg == '0 |-> wr_ptr_reg == rd_ptr_reg,
        "empty queue with pointers apart")

endmodule

// ===== rtl/core/numeric_char_reference_decoder.sv =====
// Decimal numeric character reference decoder. Bytes enter on text, one per
// transaction, and code points leave on chars. A byte is decoded in the cycle it
// is accepted, and its zero, one or two results go into a four-entry result
// queue; the first result can be taken on the next cycle. text accepts a byte
// every cycle while the queue has two free entries. chars delivers one result
// per cycle while chars is ready and the queue is not empty. Only a byte after
// a held '&' that is not '#' gives two results, and the held '&' gave none, so
// with chars always ready the queue never runs short of room and text takes one
// byte every cycle; only a stalled chars holds text off. A reference "&#...;"
// gives one result with from_reference set; an unterminated reference at end of
// text is replaced by a bare end marker (has_char low, last_out high).
`include "numeric_char_reference_decoder_macros.svh"

module numeric_char_reference_decoder (
    input  logic      clk,
    input  logic      rst_n,
    ncr_in_if.sink    text,
    ncr_out_if.source chars
);
    import ncr_pkg::*;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_AMP    = 2'd1;
    localparam logic [1:0] MODE_REF    = 2'd2;

    localparam logic [1:0] PH_SPACE  = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    logic [1:0]  mode_reg, mode_next;
    logic [1:0]  phase_reg, phase_next;
    logic        neg_reg, neg_next;
    logic [21:0] acc_reg, acc_next;

    logic        room;
    logic        accept;
    logic [7:0]  b;
    logic        last;
    logic        is_digit;
    logic        is_space;
    logic [24:0] acc_mac;
    logic [21:0] acc_step;
    ncr_item_t   end_item;
    ncr_item_t   amp_item;
    ncr_item_t   byte_item;
    ncr_item_t   ref_item;
    ncr_item_t   emit;
    logic        do_emit;
    logic        handled;
    logic [1:0]  mode_eff;
    ncr_push_t   step;
    ncr_push_t   push;

    assign b           = text.byte_in;
    assign last        = text.end_of_text;
    assign text.ready  = room;
    assign accept      = text.valid && text.ready;

    assign is_digit = b >= CH_ZERO && b <= CH_NINE;
    assign is_space = b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);

    // Times ten as two shifts, plus the digit; saturate at the clamp threshold.
    assign acc_mac  = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0} + 25'(b[3:0]);
    assign acc_step = (acc_reg >= ACC_SAT) ? acc_reg
                    : (acc_mac > 25'(ACC_SAT)) ? ACC_SAT : acc_mac[21:0];

    always_comb
    begin
        end_item = '{has_char: 1'b0, code_point: '0, from_reference: 1'b0,
                     out_of_range: 1'b0, last_out: 1'b1};
        amp_item = '{has_char: 1'b1, code_point: 21'(CH_AMP), from_reference: 1'b0,
                     out_of_range: 1'b0, last_out: 1'b0};
        byte_item = '{has_char: 1'b1, code_point: 21'(b), from_reference: 1'b0,
                      out_of_range: 1'b0, last_out: last};
        ref_item = '{has_char: 1'b1, code_point: acc_reg[20:0], from_reference: 1'b1,
                     out_of_range: 1'b0, last_out: last};
        if (neg_reg && acc_reg != '0)
        begin
            ref_item.code_point   = '0;
            ref_item.out_of_range = 1'b1;
        end
        else if (acc_reg > 22'(CP_MAX))
        begin
            ref_item.code_point   = CP_MAX;
            ref_item.out_of_range = 1'b1;
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        step       = '0;
        emit       = end_item;
        do_emit    = 1'b0;
        handled    = 1'b0;
        mode_eff   = mode_reg;

        if (mode_reg == MODE_AMP)
        begin
            if (b == CH_HASH)
            begin
                mode_next  = MODE_REF;
                phase_next = PH_SPACE;
                neg_next   = 1'b0;
                acc_next   = '0;
                do_emit    = last;
                handled    = 1'b1;
            end
            else
            begin
                // Release the held '&', then treat this byte as plain text.
                step.first = amp_item;
                step.count = PUSH_ONE;
                mode_eff   = MODE_NORMAL;
                mode_next  = MODE_NORMAL;
            end
        end

        if (!handled)
        begin
            if (mode_eff == MODE_REF)
            begin
                if (b == CH_SEMI)
                begin
                    emit       = ref_item;
                    do_emit    = 1'b1;
                    mode_next  = MODE_NORMAL;
                    phase_next = PH_SPACE;
                    neg_next   = 1'b0;
                    acc_next   = '0;
                end
                else
                begin
                    case (phase_reg)
                        PH_SPACE:
                        begin
                            if (is_space)
                            begin
                                phase_next = PH_SPACE;
                            end
                            else if (b == CH_PLUS || b == CH_MINUS)
                            begin
                                neg_next   = b == CH_MINUS;
                                phase_next = PH_DIGITS;
                            end
                            else if (!is_digit)
                            begin
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                phase_next = PH_DIGITS;
                                acc_next   = acc_step;
                            end
                        end
                        PH_DIGITS:
                        begin
                            if (!is_digit)
                            begin
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                acc_next = acc_step;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                    // Drop the open reference at end of text.
                    do_emit = last;
                end
            end
            else if (b == CH_AMP && !last)
            begin
                mode_next = MODE_AMP;
            end
            else
            begin
                emit    = byte_item;
                do_emit = 1'b1;
            end
        end

        if (do_emit)
        begin
            if (step.count == PUSH_NONE)
            begin
                step.first = emit;
                step.count = PUSH_ONE;
            end
            else
            begin
                step.second = emit;
                step.count  = PUSH_TWO;
            end
        end

        if (last)
        begin
            mode_next  = MODE_NORMAL;
            phase_next = PH_SPACE;
            neg_next   = 1'b0;
            acc_next   = '0;
        end
    end

    always_comb
    begin
        push = step;
        if (!accept)
        begin
            push.count = PUSH_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NORMAL;
            phase_reg <= PH_SPACE;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
        end
    end

    ncr_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .chars (chars)
    );

    `NCR_ASSERT_ALWAYS(a_acc_sat, acc_reg <= ACC_SAT, "accumulator above saturation")
    `NCR_ASSERT(a_end_clears, accept && last |=>
        mode_reg == MODE_NORMAL && phase_reg == PH_SPACE && !neg_reg && acc_reg == '0,
        "state not cleared after end of text")
    `NCR_ASSERT(a_number_idle, mode_reg != MODE_REF |->
        acc_reg == '0 && !neg_reg && phase_reg == PH_SPACE,
        "number state left over outside a reference")

endmodule

// ===== verif/tb.sv =====
module tb;
    import ncr_pkg::*;

    typedef enum logic [1:0] {
        SCAN_TEXT,
        SCAN_AMP,
        SCAN_REF
    } scan_t;

    typedef enum logic [1:0] {
        NUM_LEAD,
        NUM_DIGITS,
        NUM_DONE
    } num_phase_t;

    // Traffic profile: which side idles and how often.
    typedef enum logic [1:0] {
        LOAD_RX_SLOW,
        LOAD_TX_SLOW,
        LOAD_FULL_RATE
    } load_t;

    typedef struct {
        logic [7:0] data;
        logic       eot;
        load_t      load;
        bit         drain_first;
        bit         hold_rx;
    } text_txn_t;

    localparam int PHASE_ITEMS = 400;
    localparam int RX_HOLD_CYCLES = 100;
    localparam int TAIL_CYCLES = 20;

    logic clk = 1'b0;
    logic rst_n;

    ncr_in_if  text_if();
    ncr_out_if chars_if();

    numeric_char_reference_decoder u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text_if),
        .chars (chars_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    text_txn_t text_queue[$];
    ncr_item_t pending_chars[$];
    int        error_count = 0;
    load_t     cur_load = LOAD_RX_SLOW;
    logic      stall_rx_req;
    int        rx_hold_left;

    // Stimulus build state
    load_t build_load = LOAD_RX_SLOW;
    bit    mark_drain = 1'b0;
    bit    mark_hold = 1'b0;

    // Decoder shadow state
    scan_t        scan_mode_q;
    num_phase_t   num_phase_q;
    logic         negative_q;
    logic [21:0]  value_q;

    function automatic int tx_idle_pct(load_t l);
        case (l)
            LOAD_RX_SLOW: return 31;
            LOAD_TX_SLOW: return 73;
            default:      return 0;
        endcase
    endfunction

    function automatic int rx_idle_pct(load_t l);
        case (l)
            LOAD_RX_SLOW: return 73;
            LOAD_TX_SLOW: return 31;
            default:      return 0;
        endcase
    endfunction

    function automatic void clear_number();
        num_phase_q = NUM_LEAD;
        negative_q = 1'b0;
        value_q = '0;
    endfunction

    function automatic void reset_decoder();
        scan_mode_q = SCAN_TEXT;
        clear_number();
    endfunction

    function automatic void push_char(logic has, logic [20:0] cp, logic ref_flag,
                                      logic oor, logic last);
        ncr_item_t it;
        it.has_char = has;
        it.code_point = cp;
        it.from_reference = ref_flag;
        it.out_of_range = oor;
        it.last_out = last;
        pending_chars.insert(pending_chars.size(), it);
    endfunction

    function automatic void accumulate_digit(logic [7:0] b);
        logic        is_digit;
        logic        is_ws;
        int unsigned v;
        is_digit = (b >= CH_ZERO && b <= CH_NINE);
        is_ws = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
        case (num_phase_q)
            NUM_LEAD:
            begin
                if (is_ws)
                    return;
                if (b == CH_PLUS || b == CH_MINUS)
                begin
                    negative_q = (b == CH_MINUS);
                    num_phase_q = NUM_DIGITS;
                    return;
                end
                if (!is_digit)
                begin
                    num_phase_q = NUM_DONE;
                    return;
                end
                num_phase_q = NUM_DIGITS;
            end
            NUM_DIGITS:
            begin
                if (!is_digit)
                begin
                    num_phase_q = NUM_DONE;
                    return;
                end
            end
            default:
                return;
        endcase
        // Saturate so huge numbers stay clamped
        if (value_q < ACC_SAT)
        begin
            v = value_q * 10 + (b - CH_ZERO);
            value_q = (v > ACC_SAT) ? ACC_SAT : v[21:0];
        end
    endfunction

    function automatic void predict_chars(logic [7:0] b, logic eot);
        if (scan_mode_q == SCAN_AMP)
        begin
            if (b == CH_HASH)
            begin
                scan_mode_q = SCAN_REF;
                clear_number();
                if (eot)
                begin
                    push_char(1'b0, '0, 1'b0, 1'b0, 1'b1);
                    reset_decoder();
                end
                return;
            end
            push_char(1'b1, {13'd0, CH_AMP}, 1'b0, 1'b0, 1'b0);
            scan_mode_q = SCAN_TEXT;
        end

        if (scan_mode_q == SCAN_REF)
        begin
            if (b == CH_SEMI)
            begin
                if (negative_q && value_q != 0)
                    push_char(1'b1, '0, 1'b1, 1'b1, eot);
                else if (value_q > CP_MAX)
                    push_char(1'b1, CP_MAX, 1'b1, 1'b1, eot);
                else
                    push_char(1'b1, value_q[20:0], 1'b1, 1'b0, eot);
                scan_mode_q = SCAN_TEXT;
                clear_number();
            end
            else
            begin
                accumulate_digit(b);
                // Unterminated reference: drop it, send a bare end marker
                if (eot)
                    push_char(1'b0, '0, 1'b0, 1'b0, 1'b1);
            end
        end
        else if (b == CH_AMP && !eot)
        begin
            scan_mode_q = SCAN_AMP;
        end
        else
        begin
            push_char(1'b1, {13'd0, b}, 1'b0, 1'b0, eot);
        end

        if (eot)
            reset_decoder();
    endfunction

    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    function automatic void add_byte(logic [7:0] b, logic eot);
        text_txn_t t;
        t.data = b;
        t.eot = eot;
        t.load = build_load;
        t.drain_first = mark_drain;
        t.hold_rx = mark_hold;
        mark_drain = 1'b0;
        mark_hold = 1'b0;
        text_queue.insert(text_queue.size(), t);
    endfunction

    function automatic void add_text(string s, logic eot_last);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i], eot_last && (i == s.len() - 1));
    endfunction

    function automatic logic [7:0] pick_space();
        if ($urandom_range(0, 5) == 5)
            return CH_SPACE;
        return 8'(CH_TAB + $urandom_range(0, 4));
    endfunction

    function automatic void gen_reference(bit terminated);
        int unsigned val;
        string       digits;
        add_byte(CH_AMP, 1'b0);
        add_byte(CH_HASH, 1'b0);
        repeat ($urandom_range(0, 2))
            add_byte(pick_space(), 1'b0);
        case ($urandom_range(0, 3))
            0: add_byte(CH_PLUS, 1'b0);
            1: add_byte(CH_MINUS, 1'b0);
            default: ;
        endcase
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                add_byte(CH_ZERO, 1'b0);
        case ($urandom_range(0, 5))
            0, 1: val = $urandom_range(0, 999);
            2:    val = $urandom_range(0, 32'h10FFFF);
            3:    val = $urandom_range(1114100, 1114122);
            default: val = 0;
        endcase
        case ($urandom_range(0, 5))
            0:
            begin
                // Long digit run can drive the accumulator into saturation
                repeat ($urandom_range(7, 12))
                    add_byte(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
            end
            1: ;
            default:
            begin
                digits = $sformatf("%0d", val);
                add_text(digits, 1'b0);
            end
        endcase
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3))
                add_byte(8'($urandom_range(0, 255)), 1'b0);
        if (terminated)
            add_byte(CH_SEMI, 1'b0);
    endfunction

    function automatic void gen_text();
        logic [7:0] b;
        repeat ($urandom_range(1, 10))
        begin
            case ($urandom_range(0, 9))
                0, 1: add_byte(8'($urandom_range(0, 255)), 1'b0);
                2, 3, 4, 5: gen_reference(1'b1);
                6: gen_reference(1'b0);
                7:
                begin
                    add_byte(CH_AMP, 1'b0);
                    add_byte(8'($urandom_range(0, 255)), 1'b0);
                end
                8: add_byte(CH_AMP, 1'b0);
                default:
                begin
                    case ($urandom_range(0, 3))
                        0: b = CH_SEMI;
                        1: b = CH_HASH;
                        2: b = CH_MINUS;
                        default: b = 8'(CH_ZERO + $urandom_range(0, 9));
                    endcase
                    add_byte(b, 1'b0);
                end
            endcase
        end
        case ($urandom_range(0, 5))
            0: b = CH_AMP;
            1: b = CH_SEMI;
            2: b = CH_HASH;
            3: b = 8'(CH_ZERO + $urandom_range(0, 9));
            default: b = 8'($urandom_range(0, 255));
        endcase
        add_byte(b, 1'b1);
    endfunction

    // Text driver
    always @(posedge clk or negedge rst_n)
    begin : drive_text
        text_txn_t head;
        if (!rst_n)
        begin
            text_if.valid <= 1'b0;
            text_if.byte_in <= '0;
            text_if.end_of_text <= 1'b0;
            stall_rx_req <= 1'b0;
        end
        else
        begin
            if (text_if.valid && text_if.ready)
                predict_chars(text_if.byte_in, text_if.end_of_text);

            if (text_if.valid && !text_if.ready)
            begin
                stall_rx_req <= 1'b0;
            end
            else if (text_queue.size() == 0
                     || (text_queue[0].drain_first && pending_chars.size() != 0)
                     || $urandom_range(0, 99) < tx_idle_pct(cur_load))
            begin
                text_if.valid <= 1'b0;
                stall_rx_req <= 1'b0;
            end
            else
            begin
                head = text_queue.pop_front();
                text_if.valid <= 1'b1;
                text_if.byte_in <= head.data;
                text_if.end_of_text <= head.eot;
                cur_load <= head.load;
                stall_rx_req <= head.hold_rx;
            end
        end
    end

    // Result monitor and ready driver
    always @(posedge clk or negedge rst_n)
    begin : watch_chars
        ncr_item_t exp_item;
        if (!rst_n)
        begin
            chars_if.ready <= 1'b0;
            rx_hold_left <= 0;
        end
        else
        begin
            if (chars_if.valid && chars_if.ready)
            begin
                if (pending_chars.size() == 0)
                begin
                    $error("unexpected result: code_point 0x%0h", chars_if.code_point);
                    error_count++;
                end
                else
                begin
                    exp_item = pending_chars.pop_front();
                    check_field("has_char", 32'(exp_item.has_char),
                                32'(chars_if.has_char));
                    check_field("code_point", 32'(exp_item.code_point),
                                32'(chars_if.code_point));
                    check_field("from_reference", 32'(exp_item.from_reference),
                                32'(chars_if.from_reference));
                    check_field("out_of_range", 32'(exp_item.out_of_range),
                                32'(chars_if.out_of_range));
                    check_field("last_out", 32'(exp_item.last_out),
                                32'(chars_if.last_out));
                end
            end

            if (stall_rx_req)
                rx_hold_left <= RX_HOLD_CYCLES;
            else if (rx_hold_left != 0)
                rx_hold_left <= rx_hold_left - 1;

            chars_if.ready <= !stall_rx_req && rx_hold_left == 0
                              && ($urandom_range(0, 99) >= rx_idle_pct(cur_load));
        end
    end

    initial
    begin : run_test
        int  directed_len;
        bit  held;
        text_if.valid = 1'b0;
        text_if.byte_in = '0;
        text_if.end_of_text = 1'b0;
        chars_if.ready = 1'b0;
        rst_n = 1'b0;
        reset_decoder();

        // Directed: byte extremes, held '&' cases, sign and end-of-text corners
        build_load = LOAD_RX_SLOW;
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_text("&x", 1'b0);
        add_text("&#\t-7;", 1'b0);
        add_text("&#-0;", 1'b0);
        add_text("&&", 1'b1);
        add_text("&#", 1'b1);
        add_text("&#;", 1'b1);
        directed_len = text_queue.size();

        for (int p = 0; p < 3; p++)
        begin
            build_load = load_t'(p);
            mark_drain = 1'b1;
            held = 1'b0;
            while (text_queue.size() < directed_len + (p + 1) * PHASE_ITEMS)
            begin
                if (!held && text_queue.size() >= directed_len + p * PHASE_ITEMS
                                                  + PHASE_ITEMS / 2)
                begin
                    mark_hold = 1'b1;
                    held = 1'b1;
                end
                gen_text();
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (text_queue.size() != 0 || text_if.valid)
            @(negedge clk);
        while (pending_chars.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (pending_chars.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_chars.size());
            error_count++;
        end
        if (error_count == 0)
            $display("** numeric_char_reference_decoder: PASSED **");
        else
            $display("** numeric_char_reference_decoder: FAILED **");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("** numeric_char_reference_decoder: FAILED **");
        $finish;
    end

endmodule
